### rtl/core/chp_pkg.sv
// shared constants and codes for the chained hash page table
package chp_pkg;

    // fixed field widths
    localparam int KEY_W      = 31;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 6;
    localparam int BCOUNT_W   = 7;

    // bucket count register after reset
    localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 7'd64;

    // parameter defaults
    localparam int DEF_MAX_BUCKETS  = 64;
    localparam int DEF_POOL_ENTRIES = 64;
    localparam int DEF_REF_WIDTH    = 16;

    // front/back queue depth
    localparam int QUEUE_DEPTH = 2;

    // modulo unit: key bits folded per cycle, rounds and padded key width
    localparam int MOD_STEP_BITS = 4;
    localparam int MOD_ROUNDS    = (KEY_W + MOD_STEP_BITS - 1) / MOD_STEP_BITS;
    localparam int MOD_PAD_W     = MOD_ROUNDS * MOD_STEP_BITS;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_GET = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RSV = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNUSED    = 2'd3;

endpackage

### rtl/core/chp_front.sv
// front end: takes an operation and computes its bucket by a multi-bit-per-cycle modulo
module chp_front #(
    parameter int MAX_BUCKETS = chp_pkg::DEF_MAX_BUCKETS,
    parameter int REF_WIDTH   = chp_pkg::DEF_REF_WIDTH,
    parameter int NW          = $clog2(MAX_BUCKETS + 1),
    parameter int BW          = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
    parameter int DATA_W      = chp_pkg::KIND_W + chp_pkg::KEY_W + REF_WIDTH + BW
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [chp_pkg::KIND_W-1:0]  kind,
    input  logic [chp_pkg::KEY_W-1:0]   page_number,
    input  logic [REF_WIDTH-1:0]        lru_ref,
    input  logic                        hold,
    input  logic [NW-1:0]               bucket_n,
    output logic                        q_push,
    output logic [DATA_W-1:0]           q_data,
    input  logic                        q_full
);

    localparam int RW   = NW + 1;
    localparam int CW   = (chp_pkg::MOD_ROUNDS > 1) ? $clog2(chp_pkg::MOD_ROUNDS) : 1;
    localparam int PADW = chp_pkg::MOD_PAD_W;
    localparam int STEP = chp_pkg::MOD_STEP_BITS;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MOD  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]                   state_reg;
    logic [CW-1:0]                cnt_reg;
    logic [RW-1:0]                rem_reg;
    logic [RW-1:0]                rem_next;
    logic [PADW-1:0]              key_sh_reg;
    logic [chp_pkg::KEY_W-1:0]    key_reg;
    logic [chp_pkg::KIND_W-1:0]   kind_reg;
    logic [REF_WIDTH-1:0]         ref_reg;
    logic                         accept;

    assign in_stall = (state_reg != F_IDLE) || hold;
    assign accept   = in_valid && !in_stall;

    // restoring remainder over the next group of key bits
    always_comb
    begin
        rem_next = rem_reg;
        for (int i = 0; i < STEP; i++)
        begin
            rem_next = {rem_next[RW-2:0], key_sh_reg[PADW-1-i]};
            if (rem_next >= {1'b0, bucket_n})
            begin
                rem_next = rem_next - {1'b0, bucket_n};
            end
        end
    end

    // control sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= F_MOD;
                        cnt_reg   <= CW'(chp_pkg::MOD_ROUNDS - 1);
                    end
                end
                F_MOD:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= F_PUSH;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    // item payload and remainder
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind;
            key_reg    <= page_number;
            ref_reg    <= lru_ref;
            key_sh_reg <= {{(PADW - chp_pkg::KEY_W){1'b0}}, page_number};
            rem_reg    <= '0;
        end
        else if (state_reg == F_MOD)
        begin
            rem_reg    <= rem_next;
            key_sh_reg <= key_sh_reg << STEP;
        end
    end

    // hand the classified item to the queue
    assign q_push = (state_reg == F_PUSH) && !q_full;
    assign q_data = {kind_reg, key_reg, ref_reg, rem_reg[BW-1:0]};

endmodule

### rtl/core/chp_queue.sv
// short queue between the front end and the table engine
module chp_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = chp_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slots_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slots_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/chp_back.sv
// table engine: bucket heads, entry pool, free list and chain walk
module chp_back #(
    parameter int MAX_BUCKETS  = chp_pkg::DEF_MAX_BUCKETS,
    parameter int POOL_ENTRIES = chp_pkg::DEF_POOL_ENTRIES,
    parameter int REF_WIDTH    = chp_pkg::DEF_REF_WIDTH,
    parameter int BW           = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
    parameter int DATA_W       = chp_pkg::KIND_W + chp_pkg::KEY_W + REF_WIDTH + BW
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  logic [DATA_W-1:0]             q_data,
    output logic                          q_pop,
    output logic                          clearing,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [chp_pkg::STATUS_W-1:0]  status,
    output logic [chp_pkg::SLOT_OUT_W-1:0] entry_slot,
    output logic [REF_WIDTH-1:0]          found_ref
);

    localparam int SW = $clog2(POOL_ENTRIES + 1);
    localparam int IW = $clog2(POOL_ENTRIES);
    localparam int KW = chp_pkg::KEY_W;
    localparam logic [SW-1:0] NIL = SW'(POOL_ENTRIES);

    localparam logic [3:0] B_CLEAR    = 4'd0;
    localparam logic [3:0] B_IDLE     = 4'd1;
    localparam logic [3:0] B_HEAD_RD  = 4'd2;
    localparam logic [3:0] B_HEAD     = 4'd3;
    localparam logic [3:0] B_PUT_RD   = 4'd4;
    localparam logic [3:0] B_PUT_WR   = 4'd5;
    localparam logic [3:0] B_WALK_RD  = 4'd6;
    localparam logic [3:0] B_WALK     = 4'd7;
    localparam logic [3:0] B_DEL_LINK = 4'd8;
    localparam logic [3:0] B_DONE     = 4'd9;

    // memories
    logic [SW-1:0]        heads_mem [MAX_BUCKETS];
    logic [KW-1:0]        keys_mem  [POOL_ENTRIES];
    logic [REF_WIDTH-1:0] refs_mem  [POOL_ENTRIES];
    logic [SW-1:0]        next_mem  [POOL_ENTRIES];

    logic [SW-1:0]        head_q;
    logic [KW-1:0]        key_q;
    logic [REF_WIDTH-1:0] ref_q;
    logic [SW-1:0]        next_q;

    // control registers and next values
    logic [3:0]                    state_reg, state_next;
    logic [BW-1:0]                 clr_idx_reg, clr_idx_next;
    logic [SW-1:0]                 free_reg, free_next;
    logic [SW-1:0]                 fresh_reg, fresh_next;
    logic                          out_valid_reg, out_valid_next;

    // working item registers
    logic [chp_pkg::KIND_W-1:0]    kind_reg, kind_next;
    logic [KW-1:0]                 key_reg, key_next;
    logic [REF_WIDTH-1:0]          ref_reg, ref_next;
    logic [BW-1:0]                 bkt_reg, bkt_next;
    logic [SW-1:0]                 cur_reg, cur_next;
    logic [SW-1:0]                 prev_reg, prev_next;
    logic [SW-1:0]                 nxt_reg, nxt_next;
    logic [chp_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [SW-1:0]                 res_slot_reg, res_slot_next;
    logic [REF_WIDTH-1:0]          res_ref_reg, res_ref_next;
    logic [chp_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [SW-1:0]                 out_slot_reg, out_slot_next;
    logic [REF_WIDTH-1:0]          out_ref_reg, out_ref_next;

    // memory write ports
    logic                          hw_en;
    logic [BW-1:0]                 hw_addr;
    logic [SW-1:0]                 hw_data;
    logic                          nw_en;
    logic [IW-1:0]                 nw_addr;
    logic [SW-1:0]                 nw_data;
    logic                          kw_en;
    logic [IW-1:0]                 rd_idx;
    logic [31:0]                   slot_wide;

    assign clearing  = (state_reg == B_CLEAR);
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign found_ref = out_ref_reg;
    assign slot_wide = 32'(out_slot_reg);
    assign entry_slot = slot_wide[chp_pkg::SLOT_OUT_W-1:0];

    // entry read address
    assign rd_idx = (state_reg == B_PUT_RD) ? free_reg[IW-1:0] : cur_reg[IW-1:0];

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        free_next       = free_reg;
        fresh_next      = fresh_reg;
        out_valid_next  = out_valid_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        ref_next        = ref_reg;
        bkt_next        = bkt_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        nxt_next        = nxt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_ref_next    = res_ref_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_ref_next    = out_ref_reg;
        q_pop           = 1'b0;
        hw_en           = 1'b0;
        hw_addr         = bkt_reg;
        hw_data         = NIL;
        nw_en           = 1'b0;
        nw_addr         = cur_reg[IW-1:0];
        nw_data         = free_reg;
        kw_en           = 1'b0;

        // output register empties on transfer
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_CLEAR:
            begin
                hw_en   = 1'b1;
                hw_addr = clr_idx_reg;
                hw_data = NIL;
                if (clr_idx_reg == BW'(MAX_BUCKETS - 1))
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    kind_next = q_data[DATA_W-1 -: chp_pkg::KIND_W];
                    key_next  = q_data[BW+REF_WIDTH +: KW];
                    ref_next  = q_data[BW +: REF_WIDTH];
                    bkt_next  = q_data[BW-1:0];
                    if (q_data[DATA_W-1 -: chp_pkg::KIND_W] == chp_pkg::KIND_RSV)
                    begin
                        res_status_next = chp_pkg::ST_NOT_FOUND;
                        res_slot_next   = '0;
                        res_ref_next    = '0;
                        state_next      = B_DONE;
                    end
                    else
                    begin
                        state_next = B_HEAD_RD;
                    end
                end
            end
            B_HEAD_RD:
            begin
                state_next = B_HEAD;
            end
            B_HEAD:
            begin
                if (kind_reg == chp_pkg::KIND_PUT)
                begin
                    if (free_reg == NIL)
                    begin
                        res_status_next = chp_pkg::ST_FULL;
                        res_slot_next   = '0;
                        res_ref_next    = '0;
                        state_next      = B_DONE;
                    end
                    else
                    begin
                        state_next = B_PUT_RD;
                    end
                end
                else
                begin
                    cur_next  = head_q;
                    prev_next = NIL;
                    if (head_q == NIL)
                    begin
                        res_status_next = chp_pkg::ST_NOT_FOUND;
                        res_slot_next   = '0;
                        res_ref_next    = '0;
                        state_next      = B_DONE;
                    end
                    else
                    begin
                        state_next = B_WALK_RD;
                    end
                end
            end
            B_PUT_RD:
            begin
                state_next = B_PUT_WR;
            end
            B_PUT_WR:
            begin
                // new entry goes to the head of its chain
                kw_en   = 1'b1;
                nw_en   = 1'b1;
                nw_addr = free_reg[IW-1:0];
                nw_data = head_q;
                hw_en   = 1'b1;
                hw_addr = bkt_reg;
                hw_data = free_reg;
                // a slot at the fill mark has no stored link, so the next free slot is the one after it
                if (free_reg == fresh_reg)
                begin
                    free_next  = free_reg + 1'b1;
                    fresh_next = fresh_reg + 1'b1;
                end
                else
                begin
                    free_next = next_q;
                end
                res_status_next = chp_pkg::ST_OK;
                res_slot_next   = free_reg;
                res_ref_next    = ref_reg;
                state_next      = B_DONE;
            end
            B_WALK_RD:
            begin
                state_next = B_WALK;
            end
            B_WALK:
            begin
                if (key_q == key_reg)
                begin
                    res_status_next = chp_pkg::ST_OK;
                    res_slot_next   = cur_reg;
                    res_ref_next    = ref_q;
                    if (kind_reg == chp_pkg::KIND_DEL)
                    begin
                        // freed slot goes to the head of the free list
                        nw_en      = 1'b1;
                        nw_addr    = cur_reg[IW-1:0];
                        nw_data    = free_reg;
                        free_next  = cur_reg;
                        nxt_next   = next_q;
                        state_next = B_DEL_LINK;
                    end
                    else
                    begin
                        state_next = B_DONE;
                    end
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = next_q;
                    if (next_q == NIL)
                    begin
                        res_status_next = chp_pkg::ST_NOT_FOUND;
                        res_slot_next   = '0;
                        res_ref_next    = '0;
                        state_next      = B_DONE;
                    end
                    else
                    begin
                        state_next = B_WALK_RD;
                    end
                end
            end
            B_DEL_LINK:
            begin
                // unlink from predecessor or from the bucket head
                if (prev_reg != NIL)
                begin
                    nw_en   = 1'b1;
                    nw_addr = prev_reg[IW-1:0];
                    nw_data = nxt_reg;
                end
                else
                begin
                    hw_en   = 1'b1;
                    hw_addr = bkt_reg;
                    hw_data = nxt_reg;
                end
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_ref_next    = res_ref_reg;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_idx_reg   <= '0;
            free_reg      <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            free_reg      <= free_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        ref_reg        <= ref_next;
        bkt_reg        <= bkt_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        nxt_reg        <= nxt_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_ref_reg    <= res_ref_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_ref_reg    <= out_ref_next;
    end

    // bucket head memory
    always_ff @(posedge clk)
    begin
        if (hw_en)
        begin
            heads_mem[hw_addr] <= hw_data;
        end
        head_q <= heads_mem[bkt_reg];
    end

    // entry pool memories
    always_ff @(posedge clk)
    begin
        if (kw_en)
        begin
            keys_mem[free_reg[IW-1:0]] <= key_reg;
            refs_mem[free_reg[IW-1:0]] <= ref_reg;
        end
        if (nw_en)
        begin
            next_mem[nw_addr] <= nw_data;
        end
        key_q  <= keys_mem[rd_idx];
        ref_q  <= refs_mem[rd_idx];
        next_q <= next_mem[rd_idx];
    end

endmodule

### rtl/core/chained_hash_page_table.sv
// top level of the chained hash page table
// Hash table from page number to LRU reference with separate chaining over a pool of
// POOL_ENTRIES slots. After reset the block empties every bucket head and holds in_stall
// high meanwhile; the bucket_count register can be written at any time the block is idle.
// The front end reduces the page number modulo the bucket count four bits a cycle; an item
// passes there through transfer, 8 remainder rounds and hand-off to the queue. The table
// engine then steps a put through a head read, a free-slot read and the writes; a get or
// delete reads the bucket head and walks the chain with one registered read of the entry
// memories per link, and a delete adds an unlink step. The two halves overlap through a
// two-entry queue, so the front end can take a new item while the engine still works on
// earlier ones; the front end sets the pace while chains are short, the chain walk when long.
module chained_hash_page_table #(
    parameter int MAX_BUCKETS  = chp_pkg::DEF_MAX_BUCKETS,
    parameter int POOL_ENTRIES = chp_pkg::DEF_POOL_ENTRIES,
    parameter int REF_WIDTH    = chp_pkg::DEF_REF_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [chp_pkg::BCOUNT_W-1:0]   cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [chp_pkg::KIND_W-1:0]     kind,
    input  logic [chp_pkg::KEY_W-1:0]      page_number,
    input  logic [REF_WIDTH-1:0]           lru_ref,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [chp_pkg::STATUS_W-1:0]   status,
    output logic [chp_pkg::SLOT_OUT_W-1:0] entry_slot,
    output logic [REF_WIDTH-1:0]           found_ref
);

    localparam int NW     = $clog2(MAX_BUCKETS + 1);
    localparam int BW     = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int DATA_W = chp_pkg::KIND_W + chp_pkg::KEY_W + REF_WIDTH + BW;

    logic [chp_pkg::BCOUNT_W-1:0] bucket_count_reg;
    logic [31:0]                  bc_wide;
    logic [NW-1:0]                bucket_n;
    logic                         clearing;
    logic                         q_push;
    logic                         q_pop;
    logic                         q_full;
    logic                         q_empty;
    logic [DATA_W-1:0]            q_wdata;
    logic [DATA_W-1:0]            q_rdata;

    // bucket count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= chp_pkg::BCOUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            bucket_count_reg <= cfg_wr_data;
        end
    end

    // effective bucket count, clamped to one..MAX_BUCKETS
    assign bc_wide = 32'(bucket_count_reg);
    always_comb
    begin
        if (bc_wide == 32'd0)
        begin
            bucket_n = NW'(1);
        end
        else if (bc_wide > 32'(MAX_BUCKETS))
        begin
            bucket_n = NW'(MAX_BUCKETS);
        end
        else
        begin
            bucket_n = NW'(bc_wide);
        end
    end

    chp_front #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .REF_WIDTH   (REF_WIDTH),
        .NW          (NW),
        .BW          (BW),
        .DATA_W      (DATA_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .page_number (page_number),
        .lru_ref     (lru_ref),
        .hold        (clearing),
        .bucket_n    (bucket_n),
        .q_push      (q_push),
        .q_data      (q_wdata),
        .q_full      (q_full)
    );

    chp_queue #(
        .DATA_W    (DATA_W),
        .DEPTH     (chp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    chp_back #(
        .MAX_BUCKETS  (MAX_BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES),
        .REF_WIDTH    (REF_WIDTH),
        .BW           (BW),
        .DATA_W       (DATA_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .entry_slot   (entry_slot),
        .found_ref    (found_ref)
    );

`ifndef SYNTHESIS
    // no transfer is taken while the bucket heads are being emptied
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !clearing)
        else $error("item taken during bucket clear");

    // failed operations report no slot and no reference
    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != chp_pkg::ST_OK) |-> (entry_slot == '0 && found_ref == '0))
        else $error("nonzero fields on failed operation");

    // unused status code never leaves the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != chp_pkg::ST_UNUSED)
        else $error("unused status code on output");
`endif

endmodule

### test/tb_chained_hash_page_table.sv
// self-checking testbench for the chained hash page table
`timescale 1ns / 100ps

module tb_chained_hash_page_table;

    localparam int POOL    = chp_pkg::DEF_POOL_ENTRIES;
    localparam int BUCKETS = chp_pkg::DEF_MAX_BUCKETS;
    localparam int NIL     = POOL;
    localparam int RW      = chp_pkg::DEF_REF_WIDTH;
    localparam int KW      = chp_pkg::KEY_W;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [chp_pkg::STATUS_W-1:0]   st;
        logic [chp_pkg::SLOT_OUT_W-1:0] slot;
        logic [RW-1:0]                  ref_val;
    } lookup_result_t;

    // shadow table and expected lookup results
    class page_table_scoreboard;
        int unsigned heads[BUCKETS];
        logic [KW-1:0] keys[POOL];
        logic [RW-1:0] refs[POOL];
        int unsigned links[POOL];
        int unsigned free_slot;
        int unsigned buckets_used;
        lookup_result_t pending[$];
        int mismatches;
        int checked;
        int live;

        function void clear_table();
            for (int i = 0; i < BUCKETS; i++) heads[i] = 32'(NIL);
            for (int i = 0; i < POOL; i++) links[i] = 32'(i + 1);
            free_slot = 0;
            buckets_used = 64;
            live = 0;
        endfunction

        function void set_buckets(logic [chp_pkg::BCOUNT_W-1:0] v);
            buckets_used = 32'(v);
        endfunction

        // apply one accepted operation to the shadow table
        function void note_request(logic [chp_pkg::KIND_W-1:0] op, logic [KW-1:0] key,
                                   logic [RW-1:0] r);
            int unsigned n, b, cur, prev, steps, s;
            lookup_result_t res;
            n = buckets_used;
            if (n == 0) n = 1;
            if (n > BUCKETS) n = BUCKETS;
            b = 32'(key) % n;
            res = '0;
            if (op == chp_pkg::KIND_PUT)
            begin
                s = free_slot;
                if (s >= POOL)
                begin
                    res.st = chp_pkg::ST_FULL;
                end
                else
                begin
                    free_slot = links[s];
                    keys[s] = key;
                    refs[s] = r;
                    links[s] = heads[b];
                    heads[b] = s;
                    live++;
                    res.st = chp_pkg::ST_OK;
                    res.slot = chp_pkg::SLOT_OUT_W'(s);
                    res.ref_val = r;
                end
            end
            else if (op == chp_pkg::KIND_RSV)
            begin
                res.st = chp_pkg::ST_NOT_FOUND;
            end
            else
            begin
                prev = NIL;
                cur = heads[b];
                steps = 0;
                while (steps < POOL && cur < POOL && keys[cur] != key)
                begin
                    prev = cur;
                    cur = links[cur];
                    steps++;
                end
                if (cur >= POOL || keys[cur] != key)
                begin
                    res.st = chp_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    if (op == chp_pkg::KIND_DEL)
                    begin
                        if (prev < POOL) links[prev] = links[cur];
                        else heads[b] = links[cur];
                        links[cur] = free_slot;
                        free_slot = cur;
                        live--;
                    end
                    res.st = chp_pkg::ST_OK;
                    res.slot = chp_pkg::SLOT_OUT_W'(cur);
                    res.ref_val = refs[cur];
                end
            end
            pending.push_back(res);
        endfunction

        function void check_result(lookup_result_t got);
            lookup_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d slot %0d ref %h",
                             got.st, got.slot, got.ref_val);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.st !== want.st || got.slot !== want.slot
                    || got.ref_val !== want.ref_val)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d slot %0d ref %h, got %0d %0d %h",
                             want.st, want.slot, want.ref_val,
                             got.st, got.slot, got.ref_val);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [chp_pkg::BCOUNT_W-1:0] cfg_wr_data;
    logic in_valid;
    logic in_stall;
    logic [chp_pkg::KIND_W-1:0] kind;
    logic [KW-1:0] page_number;
    logic [RW-1:0] lru_ref;
    logic out_valid;
    logic out_stall;
    logic [chp_pkg::STATUS_W-1:0] status;
    logic [chp_pkg::SLOT_OUT_W-1:0] entry_slot;
    logic [RW-1:0] found_ref;

    page_table_scoreboard table_sb;
    logic quiet_phase;
    int idle_cycles;
    int ops_sent;
    int full_seen;

    // recently used keys so lookups hit
    logic [KW-1:0] key_pool[$];

    chained_hash_page_table dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .page_number(page_number),
        .lru_ref(lru_ref),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .entry_slot(entry_slot),
        .found_ref(found_ref)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // result side: sample and check each accepted transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            table_sb.check_result('{status, entry_slot, found_ref});
    end

    // result side stall bursts
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one input transfer, with an optional gap before it
    task automatic send_op(logic [chp_pkg::KIND_W-1:0] op, logic [KW-1:0] key,
                           logic [RW-1:0] r);
        if (!quiet_phase && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= op;
        page_number <= key;
        lru_ref <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        table_sb.note_request(op, key, r);
        if (op == chp_pkg::KIND_PUT)
        begin
            key_pool.push_back(key);
            if (key_pool.size() > 40) void'(key_pool.pop_front());
        end
        ops_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (table_sb.pending.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_buckets(logic [chp_pkg::BCOUNT_W-1:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        table_sb.set_buckets(v);
    endtask

    function automatic logic [KW-1:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if ($urandom_range(0, 1))
            return KW'($urandom_range(0, 300));
        return KW'($urandom);
    endfunction

    // random mix, put-heavy or delete-heavy to sweep pool occupancy
    task automatic random_phase(int count, int put_weight);
        int unsigned roll;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                send_op(chp_pkg::KIND_RSV, KW'($urandom), RW'($urandom));
            else if (roll < 3 + put_weight)
                send_op(chp_pkg::KIND_PUT, pick_key(), RW'($urandom));
            else if (roll < 3 + put_weight + (97 - put_weight) / 2)
                send_op(chp_pkg::KIND_GET, pick_key(), RW'($urandom));
            else
                send_op(chp_pkg::KIND_DEL, pick_key(), RW'($urandom));
            if (table_sb.free_slot >= POOL) full_seen++;
        end
    endtask

    initial
    begin
        table_sb = new();
        table_sb.clear_table();
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        kind = chp_pkg::KIND_GET;
        page_number = '0;
        lru_ref = '0;
        quiet_phase = 1'b0;
        idle_cycles = 0;
        ops_sent = 0;
        full_seen = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty lookups, key and ref extremes, duplicates, unused kind
        send_op(chp_pkg::KIND_GET, '0, '0);
        send_op(chp_pkg::KIND_DEL, '1, '0);
        send_op(chp_pkg::KIND_PUT, '0, '0);
        send_op(chp_pkg::KIND_PUT, '1, '1);
        send_op(chp_pkg::KIND_PUT, 31'd64, 16'h5a5a);
        send_op(chp_pkg::KIND_PUT, 31'd64, 16'ha5a5);
        send_op(chp_pkg::KIND_GET, 31'd64, '0);
        send_op(chp_pkg::KIND_GET, '1, '0);
        send_op(chp_pkg::KIND_GET, 31'd128, '0);
        send_op(chp_pkg::KIND_DEL, 31'd64, '0);
        send_op(chp_pkg::KIND_GET, 31'd64, '0);
        send_op(chp_pkg::KIND_DEL, '0, '0);
        send_op(chp_pkg::KIND_RSV, '1, '1);
        send_op(chp_pkg::KIND_GET, 31'h2aaaaaaa, '0);
        send_op(chp_pkg::KIND_PUT, 31'h55555555, 16'h8001);

        // bucket count of zero acts as one: every key on one chain
        write_buckets('0);
        send_op(chp_pkg::KIND_PUT, 31'd7, 16'h0007);
        send_op(chp_pkg::KIND_GET, 31'd64, '0);
        send_op(chp_pkg::KIND_GET, 31'h55555555, '0);
        send_op(chp_pkg::KIND_DEL, '1, '0);
        // above range acts as the maximum
        write_buckets(7'd127);
        send_op(chp_pkg::KIND_GET, 31'd7, '0);
        send_op(chp_pkg::KIND_GET, 31'd64, '0);

        // fill the pool past full, then take it apart
        write_buckets(7'd1);
        random_phase(120, 80);
        // pause until the block is empty of work
        drain();
        random_phase(100, 15);
        write_buckets(7'd64);
        random_phase(200, 45);
        write_buckets(7'd5);
        random_phase(200, 55);
        write_buckets(7'd37);
        random_phase(150, 40);
        write_buckets(7'd2);
        random_phase(100, 60);
        write_buckets(7'd64);
        quiet_phase = 1'b1;
        random_phase(150, 45);

        drain();
        $display("%0d operations sent, %0d results checked, pool full reached %0d times",
                 ops_sent, table_sb.checked, full_seen);
        $display("bucket counts 0, 1, 2, 5, 37, 64 and 127 used, with and without backpressure");
        if (table_sb.mismatches == 0 && table_sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
